FILE: src/glob_to_regex_translator_top_assert.svh
`ifndef GLOB_TO_REGEX_TRANSLATOR_TOP_ASSERT_SVH
`define GLOB_TO_REGEX_TRANSLATOR_TOP_ASSERT_SVH

// Checks a property on every rising clock edge, reset included.
`define GTR_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

// Checks a property on every rising clock edge outside reset.
`define GTR_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`endif

FILE: src/gtr_pkg.sv
`timescale 1ns / 1ps

package gtr_pkg;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_BANG,
      MODE_BSLASH,
      MODE_NORMAL,
      MODE_CLASS,
      MODE_GROUP
   } mode_type;

   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_CARET,
      PRE_PREFIX
   } pre_type;

   typedef struct packed {
      pre_type    pre;
      logic [1:0] bs_cnt;
      logic [2:0] body_len;
      logic       body_any;
      logic [7:0] body_char;
      logic       close_en;
      logic [7:0] close_char;
      logic       mark;
      logic       last;
   } cmd_type;

   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [2:0] PREFIX_LEN   = 3'd7;
   localparam logic [2:0] ANY_LEN      = 3'd4;
   localparam logic [2:0] ANY_STAR_LEN = 3'd5;

   localparam logic [2:0] SEG_PRE   = 3'd0;
   localparam logic [2:0] SEG_BS    = 3'd1;
   localparam logic [2:0] SEG_BODY  = 3'd2;
   localparam logic [2:0] SEG_CLOSE = 3'd3;
   localparam logic [2:0] SEG_MARK  = 3'd4;
   localparam int         SEG_COUNT = 5;

   function automatic logic is_meta(input logic [7:0] c);
      return c == CH_DOT || c == CH_PIPE || c == CH_PLUS || c == CH_CARET ||
             c == CH_DOLLAR || c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   // The text "(?:/|^)".
   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_LPAREN;
         3'd1:    b = CH_QUEST;
         3'd2:    b = CH_COLON;
         3'd3:    b = CH_SLASH;
         3'd4:    b = CH_PIPE;
         3'd5:    b = CH_CARET;
         default: b = CH_RPAREN;
      endcase
      return b;
   endfunction

   // The text "[^/]*".
   function automatic logic [7:0] any_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_LBRACK;
         3'd1:    b = CH_CARET;
         3'd2:    b = CH_SLASH;
         3'd3:    b = CH_RBRACK;
         default: b = CH_STAR;
      endcase
      return b;
   endfunction

endpackage

FILE: src/gtr_front.sv
`timescale 1ns / 1ps

module gtr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic            req_tlast,
   input  logic            queue_full,
   output logic            push,
   output gtr_pkg::cmd_type push_cmd
);
   import gtr_pkg::*;

   mode_type   mode_ff, mode_in, mode_body;
   logic       cjo_ff, cjo_in;
   logic       accept, hold;
   logic [7:0] c;
   logic       last;
   cmd_type    cmd;

   assign c          = req_tdata;
   assign last       = req_tlast;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign hold       = (mode_ff == MODE_START) && !last && (c == CH_BANG || c == CH_BSLASH);

   // Next state.
   always_comb begin
      mode_body = mode_ff;
      cjo_in    = cjo_ff;
      case (mode_ff)
         MODE_CLASS: begin
            cjo_in = 1'b0;
            if (!(cjo_ff && c == CH_BANG) && c == CH_RBRACK) begin
               mode_body = MODE_NORMAL;
            end
         end
         MODE_GROUP: begin
            if (c == CH_RBRACE) begin
               mode_body = MODE_NORMAL;
            end
         end
         default: begin
            if (mode_ff == MODE_START && c == CH_BANG) begin
               mode_body = last ? MODE_START : MODE_BANG;
            end else if (mode_ff == MODE_START && c == CH_BSLASH) begin
               mode_body = last ? MODE_START : MODE_BSLASH;
            end else if (c == CH_LBRACK) begin
               mode_body = MODE_CLASS;
               cjo_in    = 1'b1;
            end else if (c == CH_LBRACE) begin
               mode_body = MODE_GROUP;
            end else begin
               mode_body = MODE_NORMAL;
            end
         end
      endcase
      mode_in = mode_body;
      if (last) begin
         mode_in = MODE_START;
         cjo_in  = 1'b0;
      end
   end

   // Command for the expander.
   always_comb begin
      logic     body_on;
      mode_type body_mode;
      body_on   = 1'b0;
      body_mode = MODE_NORMAL;
      cmd       = '0;
      cmd.last  = last;
      case (mode_ff)
         MODE_START: begin
            if (c == CH_BANG) begin
               cmd.pre = last ? PRE_PREFIX : PRE_NONE;
            end else if (c == CH_BSLASH) begin
               cmd.pre    = last ? PRE_PREFIX : PRE_NONE;
               cmd.bs_cnt = last ? 2'd1 : 2'd0;
            end else begin
               cmd.pre = (c == CH_SLASH) ? PRE_CARET : PRE_PREFIX;
               body_on = 1'b1;
            end
         end
         MODE_BANG: begin
            cmd.pre = (c == CH_SLASH) ? PRE_CARET : PRE_PREFIX;
            body_on = 1'b1;
         end
         MODE_BSLASH: begin
            cmd.pre    = PRE_PREFIX;
            cmd.bs_cnt = (c != CH_BANG) ? 2'd1 : 2'd0;
            body_on    = 1'b1;
         end
         MODE_CLASS, MODE_GROUP: begin
            body_on   = 1'b1;
            body_mode = mode_ff;
         end
         default: begin
            body_on = 1'b1;
         end
      endcase

      if (body_on) begin
         cmd.body_char = c;
         cmd.body_len  = 3'd1;
         case (body_mode)
            MODE_CLASS: begin
               if (cjo_ff && c == CH_BANG) begin
                  cmd.body_char = CH_CARET;
               end
            end
            MODE_GROUP: begin
               if (is_meta(c)) begin
                  cmd.bs_cnt = cmd.bs_cnt + 2'd1;
               end else if (c == CH_RBRACE) begin
                  cmd.body_char = CH_RPAREN;
               end else if (c == CH_COMMA) begin
                  cmd.body_char = CH_PIPE;
               end
            end
            default: begin
               if (is_meta(c)) begin
                  cmd.bs_cnt = cmd.bs_cnt + 2'd1;
               end else if (c == CH_LBRACE) begin
                  cmd.body_char = CH_LPAREN;
               end else if (c == CH_QUEST) begin
                  cmd.body_any = 1'b1;
                  cmd.body_len = ANY_LEN;
               end else if (c == CH_STAR) begin
                  cmd.body_any = 1'b1;
                  cmd.body_len = ANY_STAR_LEN;
               end else if (c == CH_SLASH && last) begin
                  cmd.body_len = 3'd0;
               end
            end
         endcase
      end

      if (last && mode_body == MODE_CLASS) begin
         cmd.close_en   = 1'b1;
         cmd.close_char = CH_RBRACK;
      end else if (last && mode_body == MODE_GROUP) begin
         cmd.close_en   = 1'b1;
         cmd.close_char = CH_RPAREN;
      end

      cmd.mark = last && cmd.pre == PRE_NONE && cmd.bs_cnt == 2'd0 &&
                 cmd.body_len == 3'd0 && !cmd.close_en;
   end

   assign push     = accept && !hold;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         cjo_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cjo_ff  <= cjo_in;
      end
   end

endmodule

FILE: src/gtr_queue.sv
`timescale 1ns / 1ps

module gtr_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gtr_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             head_valid,
   output gtr_pkg::cmd_type head_cmd,
   input  logic             pop
);
   import gtr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/gtr_back.sv
`timescale 1ns / 1ps

module gtr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  gtr_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import gtr_pkg::*;

   logic [2:0] seg_ff, seg_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] seg_len [SEG_COUNT];
   logic [2:0] cur_seg, idx_eff;
   logic       more_in_seg, any_after, final_beat, emit;
   logic [7:0] byte_out;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_present_ff, rsp_last_ff;

   always_comb begin
      case (head_cmd.pre)
         PRE_CARET:  seg_len[SEG_PRE] = 3'd1;
         PRE_PREFIX: seg_len[SEG_PRE] = PREFIX_LEN;
         default:    seg_len[SEG_PRE] = 3'd0;
      endcase
      seg_len[SEG_BS]    = {1'b0, head_cmd.bs_cnt};
      seg_len[SEG_BODY]  = head_cmd.body_len;
      seg_len[SEG_CLOSE] = {2'b00, head_cmd.close_en};
      seg_len[SEG_MARK]  = {2'b00, head_cmd.mark};
   end

   // The current segment is the first non-empty one at or after the stored one.
   always_comb begin
      cur_seg   = SEG_MARK;
      any_after = 1'b0;
      for (int s = SEG_COUNT - 1; s >= 0; s--) begin
         if (3'(s) >= seg_ff && seg_len[s] != 3'd0) begin
            cur_seg = 3'(s);
         end
      end
      for (int s = 0; s < SEG_COUNT; s++) begin
         if (3'(s) > cur_seg && seg_len[s] != 3'd0) begin
            any_after = 1'b1;
         end
      end
      idx_eff     = (cur_seg == seg_ff) ? idx_ff : 3'd0;
      more_in_seg = ({1'b0, idx_eff} + 4'd1) < {1'b0, seg_len[cur_seg]};
      final_beat  = !more_in_seg && !any_after;
   end

   always_comb begin
      case (cur_seg)
         SEG_PRE:   byte_out = (head_cmd.pre == PRE_CARET) ? CH_CARET : prefix_byte(idx_eff);
         SEG_BS:    byte_out = CH_BSLASH;
         SEG_BODY:  byte_out = head_cmd.body_any ? any_byte(idx_eff) : head_cmd.body_char;
         SEG_CLOSE: byte_out = head_cmd.close_char;
         default:   byte_out = 8'h00;
      endcase
   end

   assign emit = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = emit && final_beat;

   always_comb begin
      seg_in = seg_ff;
      idx_in = idx_ff;
      if (emit) begin
         if (final_beat) begin
            seg_in = SEG_PRE;
            idx_in = 3'd0;
         end else if (more_in_seg) begin
            seg_in = cur_seg;
            idx_in = idx_eff + 3'd1;
         end else begin
            seg_in = cur_seg + 3'd1;
            idx_in = 3'd0;
         end
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_PRE;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff    <= byte_out;
         rsp_present_ff <= cur_seg != SEG_MARK;
         rsp_last_ff    <= final_beat && head_cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_present_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/glob_to_regex_translator_top.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata          tuser          tlast
// req_      in         glob_char[7:0] -              end_of_glob
// rsp_      out        regex_char[7:0] char_present  end_of_regex
//
// One regex byte leaves per cycle while rsp_ does not stall; a glob byte
// yields from 1 to 13 of them, and a held leading '!' or backslash yields none.
// The expander in the back part produces these bytes, one per cycle.
// Reset is synchronous and empties the queue and the output register.
// The front keeps accepting while the queue has room, even if rsp_ stalls.
module glob_to_regex_translator_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // glob_char[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // regex_char[7:0]
   output logic [0:0] rsp_tuser,   // char_present[0]
   output logic       rsp_tlast
);
   import gtr_pkg::*;

   logic    push, queue_full, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   gtr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   gtr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   gtr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/gtr_checker.sv
`timescale 1ns / 1ps
`include "glob_to_regex_translator_top_assert.svh"

module gtr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast);
   endproperty

   property p_bare_mark;
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'h00;
   endproperty

   property p_reset_idle;
      reset ##1 !reset |-> !rsp_tvalid;
   endproperty

   property p_req_known;
      req_tvalid && req_tready |-> !$isunknown({req_tdata, req_tlast});
   endproperty

   // A stalled result beat keeps its contents.
   `GTR_ASSERT_RUN(a_rsp_hold, p_rsp_hold, "rsp beat changed while stalled")

   // A beat without a character is a bare end marker with a zero byte.
   `GTR_ASSERT_RUN(a_bare_mark, p_bare_mark, "bare marker malformed")

   // Nothing is offered in the cycle after reset.
   `GTR_ASSERT_CLK(a_reset_idle, p_reset_idle, "rsp valid right after reset")

   // An accepted request beat carries known data.
   `GTR_ASSERT_RUN(a_req_known, p_req_known, "req beat accepted with unknown data")

endmodule

bind glob_to_regex_translator_top gtr_checker u_gtr_checker (.*);
